[rtl/pfc_pkg.sv]
// Shared types and format codes for the pixel format converter.
// No dependencies; compiled first.
package pfc_pkg;

	// Packed pixel format codes
	typedef logic [1:0] fmt_t;
	localparam fmt_t FMT_565  = 2'd0;
	localparam fmt_t FMT_5551 = 2'd1;
	localparam fmt_t FMT_4444 = 2'd2;
	localparam fmt_t FMT_8888 = 2'd3;

	// Configuration register indexes
	typedef logic cfg_idx_t;
	localparam cfg_idx_t REG_SRC_FORMAT = 1'b0;
	localparam cfg_idx_t REG_DST_FORMAT = 1'b1;

	localparam int PIX_W = 32;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [7:0] chan_t;

	// One pixel with every channel widened to 8 bits
	typedef struct packed {
		chan_t alpha;
		chan_t c2;
		chan_t c1;
		chan_t c0;
	} argb_t;

endpackage

[rtl/pfc_if.sv]
// Valid/ready channel interfaces for source pixels and converted pixels.
// Depends on pfc_pkg.
interface pfc_in_if;
	logic          valid;
	logic          ready;
	pfc_pkg::pix_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface pfc_out_if;
	logic          valid;
	logic          ready;
	pfc_pkg::pix_t pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink (input valid, input pixel_out, output ready);
endinterface

[rtl/pfc_unpack.sv]
// Splits a source pixel into its channels and widens each to 8 bits.
// Depends on pfc_pkg.
module pfc_unpack (
	input  pfc_pkg::fmt_t  fmt,
	input  pfc_pkg::pix_t  pixel,
	output pfc_pkg::argb_t chans
);
	import pfc_pkg::*;

	// Widening repeats the top bits into the new low bits
	function automatic chan_t wid5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic chan_t wid6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic chan_t wid4(input logic [3:0] v);
		return {v, v};
	endfunction

	// Format decode; upper half ignored for 16-bit formats
	always_comb begin
		unique case (fmt)
			FMT_565: begin
				chans.c0    = wid5(pixel[4:0]);
				chans.c1    = wid6(pixel[10:5]);
				chans.c2    = wid5(pixel[15:11]);
				chans.alpha = 8'hff;
			end
			FMT_5551: begin
				chans.c0    = wid5(pixel[4:0]);
				chans.c1    = wid5(pixel[9:5]);
				chans.c2    = wid5(pixel[14:10]);
				chans.alpha = {8{pixel[15]}};
			end
			FMT_4444: begin
				chans.c0    = wid4(pixel[3:0]);
				chans.c1    = wid4(pixel[7:4]);
				chans.c2    = wid4(pixel[11:8]);
				chans.alpha = wid4(pixel[15:12]);
			end
			default: begin
				chans.c0    = pixel[7:0];
				chans.c1    = pixel[15:8];
				chans.c2    = pixel[23:16];
				chans.alpha = pixel[31:24];
			end
		endcase
	end

endmodule

[rtl/pixel_format_convert.sv]
// Pixel format converter top level: config registers, three-stage pipeline, repack.
// Depends on pfc_pkg, pfc_if and pfc_unpack.
//
//   port    | direction | payload       | handshake
//   --------+-----------+---------------+---------------------------
//   pix     | sink      | pixel_in[31:0]  | valid/ready
//   conv    | source    | pixel_out[31:0] | valid/ready
//   cfg_*   | sink      | index, data[1:0]| write enable, no wait
//
// One word per clock sustained while conv.ready holds; each word passes the input,
// unpack and repack registers in turn. Each stage advances when it is empty or the
// stage after it advances, so a stall holds every word in place and bubbles
// are squeezed out. Reset clears the valid bits and sets both formats to 8888.
module pixel_format_convert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pfc_pkg::cfg_idx_t   cfg_index,
	input  pfc_pkg::fmt_t       cfg_wdata,
	pfc_in_if.sink              pix,
	pfc_out_if.source           conv
);
	import pfc_pkg::*;

	fmt_t   src_format_q, dst_format_q;

	logic   vld_s1, vld_s2, vld_s3;
	logic   adv_s1, adv_s2, adv_s3;
	pix_t   pixel_s1;
	fmt_t   src_s1, dst_s1, dst_s2;
	argb_t  chans_s2, chans_w;
	pix_t   packed_w, pixel_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_format_q <= FMT_8888;
			dst_format_q <= FMT_8888;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_FORMAT: src_format_q <= cfg_wdata;
				REG_DST_FORMAT: dst_format_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stall chain
	assign adv_s3    = !vld_s3 || conv.ready;
	assign adv_s2    = !vld_s2 || adv_s3;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign pix.ready = adv_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pix.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: capture word and formats
	always_ff @(posedge clk) begin
		if (adv_s1 && pix.valid) begin
			pixel_s1 <= pix.pixel_in;
			src_s1   <= src_format_q;
			dst_s1   <= dst_format_q;
		end
	end

	pfc_unpack u_unpack (
		.fmt   (src_s1),
		.pixel (pixel_s1),
		.chans (chans_w)
	);

	// Stage 2: widened channels
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			chans_s2 <= chans_w;
			dst_s2   <= dst_s1;
		end
	end

	// Narrow to the destination widths and pack
	always_comb begin
		unique case (dst_s2)
			FMT_565: packed_w = {16'h0000, chans_s2.c2[7:3], chans_s2.c1[7:2],
				chans_s2.c0[7:3]};
			FMT_5551: packed_w = {16'h0000, chans_s2.alpha[7], chans_s2.c2[7:3],
				chans_s2.c1[7:3], chans_s2.c0[7:3]};
			FMT_4444: packed_w = {16'h0000, chans_s2.alpha[7:4], chans_s2.c2[7:4],
				chans_s2.c1[7:4], chans_s2.c0[7:4]};
			default: packed_w = {chans_s2.alpha, chans_s2.c2, chans_s2.c1,
				chans_s2.c0};
		endcase
	end

	// Stage 3: output register
	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			pixel_s3 <= packed_w;
		end
	end

	assign conv.valid     = vld_s3;
	assign conv.pixel_out = pixel_s3;

endmodule

[verif/pixel_format_convert_tb.sv]
// Self-checking testbench for pixel_format_convert: drives pixel words with random gaps and
// back-pressure, and checks every converted word against a predictor held in the bench.
// Depends on pfc_pkg, pfc_if and the RTL of the converter.
`timescale 1ns / 100ps

module pixel_format_convert_tb;
	import pfc_pkg::*;

	localparam int  RANDOM_WORDS = 500;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  SETTLE_CYCLES = 10;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	fmt_t     cfg_wdata;

	pfc_in_if  pix_if ();
	pfc_out_if conv_if ();

	pixel_format_convert DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_if),
		.conv      (conv_if)
	);

	// Bench copy of the format registers
	fmt_t src_fmt;
	fmt_t dst_fmt;

	// Converted words still owed by the block, oldest first
	pix_t owed_words[$];

	int    mismatches;
	int    words_sent;
	int    words_checked;
	int    cycles;
	bit    sink_stalls;
	bit    source_gaps;
	int    stall_left;

	fmt_t  all_fmts[4] = '{FMT_565, FMT_5551, FMT_4444, FMT_8888};

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Bit position of a channel within a packed format (alpha is channel 3)
	function automatic int chan_pos(fmt_t f, int ch);
		case (f)
			FMT_565: begin
				return (ch == 0) ? 0 : (ch == 1) ? 5 : (ch == 2) ? 11 : 16;
			end
			FMT_5551: begin
				return ch * 5;
			end
			FMT_4444: begin
				return ch * 4;
			end
			default: begin
				return ch * 8;
			end
		endcase
	endfunction

	// Channel width in bits; zero where the format has no such channel
	function automatic int chan_width(fmt_t f, int ch);
		case (f)
			FMT_565: begin
				return (ch == 1) ? 6 : (ch == 3) ? 0 : 5;
			end
			FMT_5551: begin
				return (ch == 3) ? 1 : 5;
			end
			FMT_4444: begin
				return 4;
			end
			default: begin
				return 8;
			end
		endcase
	endfunction

	// Widen a w-bit channel to 8 bits by repeating its bit pattern from the top
	function automatic chan_t widen_chan(chan_t v, int w);
		chan_t e;
		for (int i = 7; i >= 0; i--)
			e[i] = v[w - 1 - ((7 - i) % w)];
		return e;
	endfunction

	// Expected output word for one input word under the given formats
	function automatic pix_t convert_pixel(fmt_t src, fmt_t dst, pix_t px);
		pix_t  word;
		pix_t  res;
		chan_t e;
		int    sw;
		int    dw;
		word = px;
		if (src != FMT_8888)
			word[31:16] = '0;
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			sw = chan_width(src, ch);
			dw = chan_width(dst, ch);
			// missing alpha reads as opaque
			e = (sw == 0) ? 8'hff : widen_chan(chan_t'(word >> chan_pos(src, ch)), sw);
			if (dw != 0)
				res |= (pix_t'(e) >> (8 - dw)) << chan_pos(dst, ch);
		end
		if (dst != FMT_8888)
			res[31:16] = '0;
		return res;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < 40)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Output ready with random stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			conv_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			conv_if.ready <= 1'b1;
			if (sink_stalls && $urandom_range(0, 99) < 20)
				stall_left <= gap_len();
		end
	end

	// Both handshakes in one process: retire the oldest owed word, then log the new one
	always @(posedge clk) begin
		if (arst_n && conv_if.valid && conv_if.ready) begin
			if (owed_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %08h", conv_if.pixel_out));
			end else begin
				if (conv_if.pixel_out !== owed_words[0])
					report_mismatch($sformatf("pixel_out %08h, expected %08h",
						conv_if.pixel_out, owed_words[0]));
				void'(owed_words.pop_front());
				words_checked++;
			end
		end
		if (arst_n && pix_if.valid && pix_if.ready)
			owed_words.push_back(convert_pixel(src_fmt, dst_fmt, pix_if.pixel_in));
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d words owed", cycles, owed_words.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one word and hold it until it is taken
	task automatic send_pixel(pix_t px);
		@(negedge clk);
		pix_if.valid    <= 1'b1;
		pix_if.pixel_in <= px;
		do
			@(posedge clk);
		while (!pix_if.ready);
		words_sent++;
	endtask

	task automatic source_idle(int n);
		if (n > 0) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every owed word has come back
	task automatic wait_drained();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (owed_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_format(cfg_idx_t idx, fmt_t f);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= f;
		if (idx == REG_SRC_FORMAT)
			src_fmt = f;
		else
			dst_fmt = f;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_formats(fmt_t src, fmt_t dst);
		wait_drained();
		write_format(REG_SRC_FORMAT, src);
		write_format(REG_DST_FORMAT, dst);
	endtask

	// Reset formats are 8888 both ways: plain pass-through
	task automatic test_reset_passthrough();
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h8000_0001);
	endtask

	// Every source/destination pair once, with upper bits set in most words on 16-bit sources
	task automatic test_format_pairs();
		pix_t patterns[4] = '{32'hffff_ffff, 32'h0000_0000, 32'hffff_0000, 32'h5a5a_a5a5};
		int   n;
		n = 0;
		foreach (all_fmts[s]) begin
			foreach (all_fmts[d]) begin
				set_formats(all_fmts[s], all_fmts[d]);
				send_pixel(patterns[n % 4]);
				n++;
			end
		end
	endtask

	// Random words in phases of random formats, idling switched per phase
	task automatic test_random_stream();
		int   target;
		int   phase_len;
		int   pick;
		pix_t px;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			set_formats(all_fmts[$urandom_range(0, 3)], all_fmts[$urandom_range(0, 3)]);
			sink_stalls = ($urandom_range(0, 3) != 0);
			source_gaps = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(10, 60);
			repeat (phase_len) begin
				pick = $urandom_range(0, 19);
				px = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hffff_ffff : $urandom;
				send_pixel(px);
				if (source_gaps && $urandom_range(0, 99) < 25)
					source_idle(gap_len());
				// occasional hold-off until the pipeline has emptied
				if ($urandom_range(0, 99) < 2)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_SRC_FORMAT;
		cfg_wdata       = FMT_8888;
		pix_if.valid    = 1'b0;
		pix_if.pixel_in = '0;
		conv_if.ready   = 1'b0;
		src_fmt         = FMT_8888;
		dst_fmt         = FMT_8888;
		mismatches      = 0;
		words_sent      = 0;
		words_checked   = 0;
		cycles          = 0;
		sink_stalls     = 1'b0;
		source_gaps     = 1'b0;
		stall_left      = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_passthrough();
		sink_stalls = 1'b1;
		test_format_pairs();
		test_random_stream();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Converted %0d words (%0d checked) across all 16 format pairs,",
			words_sent, words_checked);
		$display("with random source gaps and sink stalls; %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
